// ===== rtl/haversine_great_circle_distance_assert.svh =====
// assertion macros for the distance pipeline, clocked on clk, quiet in reset
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define HGCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HGCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hgcd_pkg.sv =====
package hgcd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int NC = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CW = 34;
  localparam int SQ_STAGES = 31;
  localparam int SQ_W = 2 * SQ_STAGES;
  localparam int NL = 4;
  localparam int NPIPE = 5 + NC + 4 + SQ_STAGES + NC + 4;
  localparam int V_QM = 3;
  localparam int V_COS = 5 + NC;

  // lanes of the angle conversion
  localparam int LN_DLAT = 0;
  localparam int LN_DLON = 1;
  localparam int LN_LATA = 2;
  localparam int LN_LATB = 3;

  // cordic modes
  localparam logic MODE_ROT = 1'b0;
  localparam logic MODE_VEC = 1'b1;

  localparam logic [31:0] DEG7_U = 32'd3600000000;
  localparam logic signed [34:0] DEG7_S = 35'sd3600000000;
  localparam logic signed [34:0] DEG7_S2 = 35'sd7200000000;
  localparam logic [32:0] TURN_RECIP = 33'd5124095576;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_S = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_S = 34'sd2147483648;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [24:0] DIST_MAX = 25'h1FF_FFFF;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cvec_t;

  // atan(2^-i) in 2^32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0: a = 32'd536870912;
      5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;
      5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;
      5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;
      5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;
      5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/hgcd_in_if.sv =====
interface hgcd_in_if;
  logic valid;
  logic ready;
  logic signed [30:0] lat_a;
  logic signed [31:0] lon_a;
  logic signed [30:0] lat_b;
  logic signed [31:0] lon_b;

  modport source(output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                 input ready);
  modport sink(input valid, input lat_a, input lon_a, input lat_b, input lon_b,
               output ready);
endinterface

// ===== rtl/hgcd_out_if.sv =====
interface hgcd_out_if;
  logic valid;
  logic ready;
  logic [24:0] distance_m;

  modport source(output valid, output distance_m, input ready);
  modport sink(input valid, input distance_m, output ready);
endinterface

// ===== rtl/hgcd_cordic.sv =====
module hgcd_cordic (
  input  logic           clk,
  input  logic           en,
  input  logic           vec_mode,
  input  hgcd_pkg::cvec_t vin,
  output hgcd_pkg::cvec_t vout
);

  hgcd_pkg::cvec_t stg_r [hgcd_pkg::NC];

  for (genvar i = 0; i < hgcd_pkg::NC; i++) begin : g_stage
    hgcd_pkg::cvec_t stg_in;
    hgcd_pkg::cvec_t stg_nxt;
    logic ccw;
    logic signed [hgcd_pkg::CW-1:0] a;

    if (i == 0) begin : g_first
      assign stg_in = vin;
    end else begin : g_rest
      assign stg_in = stg_r[i-1];
    end

    assign a = $signed({2'b00, hgcd_pkg::atan_turn(5'(i))});

    always_comb begin
      ccw = (vec_mode == hgcd_pkg::MODE_VEC) ? stg_in.y[hgcd_pkg::CW-1]
                                              : !stg_in.z[hgcd_pkg::CW-1];
      if (ccw) begin
        stg_nxt.x = stg_in.x - (stg_in.y >>> i);
        stg_nxt.y = stg_in.y + (stg_in.x >>> i);
        stg_nxt.z = stg_in.z - a;
      end else begin
        stg_nxt.x = stg_in.x + (stg_in.y >>> i);
        stg_nxt.y = stg_in.y - (stg_in.x >>> i);
        stg_nxt.z = stg_in.z + a;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[i] <= stg_nxt;
      end
    end
  end

  assign vout = stg_r[hgcd_pkg::NC-1];

endmodule

// ===== rtl/hgcd_sqrt.sv =====
module hgcd_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [hgcd_pkg::SQ_W-2:0]      v_in,
  output logic [hgcd_pkg::SQ_STAGES-1:0] root
);

  logic [hgcd_pkg::SQ_W-1:0] rem_r [hgcd_pkg::SQ_STAGES];
  logic [hgcd_pkg::SQ_W-1:0] res_r [hgcd_pkg::SQ_STAGES];

  for (genvar k = 0; k < hgcd_pkg::SQ_STAGES; k++) begin : g_stage
    localparam logic [hgcd_pkg::SQ_W-1:0] BIT =
      hgcd_pkg::SQ_W'(1) << (2 * (hgcd_pkg::SQ_STAGES - 1 - k));
    logic [hgcd_pkg::SQ_W-1:0] rem_in, res_in, trial;
    logic [hgcd_pkg::SQ_W-1:0] rem_nxt, res_nxt;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, v_in};
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[hgcd_pkg::SQ_STAGES-1][hgcd_pkg::SQ_STAGES-1:0];

endmodule

// ===== rtl/haversine_great_circle_distance.sv =====
// Haversine great-circle distance in whole metres between two points given in
// signed 1e-7 degree units. A fully pipelined datapath takes one point pair
// per cycle unless stalled and returns its distance through these stages:
// five stages convert the angles to turns, a cosine CORDIC chain runs per
// angle, four stages form hav, a 31-stage square-root pipeline and
// an arctangent CORDIC chain give the central angle, and four stages scale it
// by the radius and round. Back-pressure on the result stalls the whole
// pipeline without losing items. cfg_wdata sets the radius in metres (reset
// 6371000); write it only while the pipeline holds no items.
`include "haversine_great_circle_distance_assert.svh"

module haversine_great_circle_distance (
  input  logic              clk,
  input  logic              rst_n,
  hgcd_in_if.sink           in_chan,
  hgcd_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [22:0]       cfg_wdata
);

  logic                        adv;
  logic [hgcd_pkg::NPIPE-1:0]  vld_r;
  logic [22:0]                 radius_r;

  logic signed [34:0] ang_nxt [hgcd_pkg::NL];
  logic signed [34:0] ang_r   [hgcd_pkg::NL];
  logic [31:0]        red_r   [hgcd_pkg::NL];
  logic [31:0]        red3_r  [hgcd_pkg::NL];
  logic [31:0]        red4_r  [hgcd_pkg::NL];
  logic [32:0]        q_r     [hgcd_pkg::NL];
  logic [32:0]        q4_r    [hgcd_pkg::NL];
  logic [64:0]        qm_r    [hgcd_pkg::NL];
  logic [64:0]        rem     [hgcd_pkg::NL];
  logic [31:0]        turn_r  [hgcd_pkg::NL];
  logic [hgcd_pkg::NC-1:0] neg_r [hgcd_pkg::NL];
  hgcd_pkg::cvec_t    cin     [hgcd_pkg::NL];
  hgcd_pkg::cvec_t    cout    [hgcd_pkg::NL];
  logic signed [31:0] cos_r   [hgcd_pkg::NL];

  logic signed [33:0] t1_full, t2_full;
  logic [30:0]        t1_nxt, t2_nxt, t1_r, t2_r, t1b_r;
  logic signed [63:0] cc_prod, hp_prod;
  logic signed [31:0] cc_r;
  logic signed [33:0] hp_r;
  logic signed [34:0] hav_sum;
  logic [30:0]        hav_nxt, hav_r;
  logic [30:0]        s_h, s_c;
  hgcd_pkg::cvec_t    at_in, at_out;
  logic [30:0]        zc_nxt, zc_r;
  logic [62:0]        zp;
  logic [33:0]        angp_r;
  logic [56:0]        rp_r;
  logic [57:0]        rsum;
  logic [24:0]        dist_nxt, dist_r;

  assign adv = !vld_r[hgcd_pkg::NPIPE-1] || out_chan.ready;
  assign in_chan.ready = adv;
  assign out_chan.valid = vld_r[hgcd_pkg::NPIPE-1];
  assign out_chan.distance_m = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[hgcd_pkg::NPIPE-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= hgcd_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // angle differences and latitudes
  always_comb begin
    ang_nxt[hgcd_pkg::LN_DLAT] = 35'(in_chan.lat_b) - 35'(in_chan.lat_a);
    ang_nxt[hgcd_pkg::LN_DLON] = 35'(in_chan.lon_b) - 35'(in_chan.lon_a);
    ang_nxt[hgcd_pkg::LN_LATA] = 35'(in_chan.lat_a);
    ang_nxt[hgcd_pkg::LN_LATB] = 35'(in_chan.lat_b);
  end

  for (genvar l = 0; l < hgcd_pkg::NL; l++) begin : g_lane
    logic signed [34:0] red_sel;
    logic [64:0]        rcp_prod;
    logic [64:0]        qm_nxt;
    logic [64:0]        num;
    logic [1:0]         corr;
    logic signed [hgcd_pkg::CW-1:0] zs, zf;
    logic               fneg;

    // reduce into one turn of 1e-7 degrees
    always_comb begin
      if (ang_r[l] < -hgcd_pkg::DEG7_S) begin
        red_sel = ang_r[l] + hgcd_pkg::DEG7_S2;
      end else if (ang_r[l] < 35'sd0) begin
        red_sel = ang_r[l] + hgcd_pkg::DEG7_S;
      end else if (ang_r[l] >= hgcd_pkg::DEG7_S) begin
        red_sel = ang_r[l] - hgcd_pkg::DEG7_S;
      end else begin
        red_sel = ang_r[l];
      end
    end

    assign rcp_prod = 65'(red_r[l]) * 65'(hgcd_pkg::TURN_RECIP);
    assign qm_nxt = 65'(q_r[l]) * 65'(hgcd_pkg::DEG7_U);

    // rounding correction of the reciprocal quotient
    always_comb begin
      num = {1'b0, red4_r[l], 32'd0} + 65'(hgcd_pkg::DEG7_U >> 1);
      rem[l] = num - qm_r[l];
      if (rem[l] >= (65'(hgcd_pkg::DEG7_U) << 1)) begin
        corr = 2'd2;
      end else if (rem[l] >= 65'(hgcd_pkg::DEG7_U)) begin
        corr = 2'd1;
      end else begin
        corr = 2'd0;
      end
    end

    // fold into plus or minus a quarter turn
    always_comb begin
      zs = hgcd_pkg::CW'($signed(turn_r[l]));
      fneg = 1'b0;
      zf = zs;
      if (zs > hgcd_pkg::QUARTER_S) begin
        zf = zs - hgcd_pkg::HALF_S;
        fneg = 1'b1;
      end else if (zs < -hgcd_pkg::QUARTER_S) begin
        zf = zs + hgcd_pkg::HALF_S;
        fneg = 1'b1;
      end
      cin[l].x = hgcd_pkg::CORDIC_K;
      cin[l].y = '0;
      cin[l].z = zf;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ang_r[l]  <= ang_nxt[l];
        red_r[l]  <= 32'(red_sel);
        q_r[l]    <= rcp_prod[64:32];
        red3_r[l] <= red_r[l];
        qm_r[l]   <= qm_nxt;
        q4_r[l]   <= q_r[l];
        red4_r[l] <= red3_r[l];
        turn_r[l] <= 32'(q4_r[l] + 33'(corr));
        neg_r[l]  <= {neg_r[l][hgcd_pkg::NC-2:0], fneg};
        cos_r[l]  <= neg_r[l][hgcd_pkg::NC-1] ? 32'(-cout[l].x) : 32'(cout[l].x);
      end
    end

    hgcd_cordic u_cos (
      .clk      (clk),
      .en       (adv),
      .vec_mode (hgcd_pkg::MODE_ROT),
      .vin      (cin[l]),
      .vout     (cout[l])
    );
  end

  // haversine terms
  always_comb begin
    t1_full = (34'($signed({1'b0, hgcd_pkg::Q30_ONE})) - 34'(cos_r[hgcd_pkg::LN_DLAT])) >>> 1;
    t2_full = (34'($signed({1'b0, hgcd_pkg::Q30_ONE})) - 34'(cos_r[hgcd_pkg::LN_DLON])) >>> 1;
    t1_nxt = t1_full[33] ? '0 : t1_full[30:0];
    t2_nxt = t2_full[33] ? '0 : t2_full[30:0];
    cc_prod = 64'(cos_r[hgcd_pkg::LN_LATA]) * 64'(cos_r[hgcd_pkg::LN_LATB]);
    hp_prod = 64'(cc_r) * 64'($signed({1'b0, t2_r}));
    hav_sum = 35'($signed({1'b0, t1b_r})) + 35'(hp_r);
    if (hav_sum[34]) begin
      hav_nxt = '0;
    end else if (hav_sum > 35'($signed({1'b0, hgcd_pkg::Q30_ONE}))) begin
      hav_nxt = hgcd_pkg::Q30_ONE;
    end else begin
      hav_nxt = hav_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r  <= t1_nxt;
      t2_r  <= t2_nxt;
      cc_r  <= 32'(cc_prod >>> 30);
      t1b_r <= t1_r;
      hp_r  <= 34'(hp_prod >>> 30);
      hav_r <= hav_nxt;
    end
  end

  hgcd_sqrt u_sqrt_h (
    .clk  (clk),
    .en   (adv),
    .v_in ({hav_r, 30'd0}),
    .root (s_h)
  );

  hgcd_sqrt u_sqrt_c (
    .clk  (clk),
    .en   (adv),
    .v_in ({31'(hgcd_pkg::Q30_ONE - hav_r), 30'd0}),
    .root (s_c)
  );

  always_comb begin
    at_in.x = $signed({3'b000, s_c});
    at_in.y = $signed({3'b000, s_h});
    at_in.z = '0;
  end

  hgcd_cordic u_atan (
    .clk      (clk),
    .en       (adv),
    .vec_mode (hgcd_pkg::MODE_VEC),
    .vin      (at_in),
    .vout     (at_out)
  );

  // central angle to metres
  always_comb begin
    if (at_out.z[hgcd_pkg::CW-1]) begin
      zc_nxt = '0;
    end else if (at_out.z > 34'($signed({1'b0, hgcd_pkg::Q30_ONE}))) begin
      zc_nxt = hgcd_pkg::Q30_ONE;
    end else begin
      zc_nxt = at_out.z[30:0];
    end
    zp = 63'(zc_r) * 63'(hgcd_pkg::PI_Q30);
    rsum = {1'b0, rp_r} + (58'(1) << 31);
    if (rsum[57:32] > 26'(hgcd_pkg::DIST_MAX)) begin
      dist_nxt = hgcd_pkg::DIST_MAX;
    end else begin
      dist_nxt = rsum[56:32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zc_r   <= zc_nxt;
      angp_r <= zp[61:28];
      rp_r   <= 57'(radius_r) * 57'(angp_r);
      dist_r <= dist_nxt;
    end
  end

  `HGCD_ASSERT_IMP(a_turn_rem, vld_r[hgcd_pkg::V_QM],
    rem[hgcd_pkg::LN_DLON] < 65'(3) * 65'(hgcd_pkg::DEG7_U), "turn quotient off by more than two")
  `HGCD_ASSERT_IMP(a_cos_range, vld_r[hgcd_pkg::V_COS],
    cos_r[hgcd_pkg::LN_DLAT] <= 32'sd1074790400 && cos_r[hgcd_pkg::LN_DLAT] >= -32'sd1074790400,
    "cosine out of range")
  `HGCD_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_r), "pipeline moved during stall")
  `HGCD_ASSERT_NXT(a_enter, in_chan.valid && in_chan.ready, vld_r[0], "transfer not captured")

endmodule
